// ===== hw/rtl/qvt_pkg.sv =====
// qvt_pkg: shared types and constants for the q value table block
// used by qvt_ctrl, qvt_datapath and q_value_table_with_argmax; no dependencies
`timescale 1ns / 1ps

package qvt_pkg;

    // table geometry
    localparam int NUM_CODES      = 27;
    localparam int TABLE_DEPTH    = NUM_CODES * NUM_CODES;
    localparam int ADDR_W         = $clog2(TABLE_DEPTH);
    localparam int IDX_W          = $clog2(NUM_CODES);
    localparam int CODE_W         = 2;
    localparam int OUT_VALUE_W    = 32;
    localparam int VALUE_WIDTH_DEF = 32;

    // operation codes
    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_BEST  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    // commands from controller to datapath
    typedef struct packed {
        logic latch;       // capture the input beat
        logic clear_wr;    // write zero at the sweep counter
        logic write;       // write the captured value
        logic scan_issue;  // read one action entry of the scan
        logic finish;      // load the result registers
    } t_ctrl_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic clear_last;  // sweep counter on the last table entry
        logic scan_last;   // scan counter on the last action
    } t_dp_status;

endpackage

// ===== hw/rtl/qvt_ctrl.sv =====
// qvt_ctrl: sequencing state machine for the q value table
// depends on qvt_pkg for op codes and the command/status structs
`timescale 1ns / 1ps

module qvt_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic [1:0]            i_op,
    input  qvt_pkg::t_dp_status   i_status,
    output qvt_pkg::t_ctrl_cmd    o_cmd,
    output logic                  busy,
    output logic                  o_strobe
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_WRITE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_strobe;
    logic   w_accept;
    qvt_pkg::t_op w_op;

    assign w_op     = qvt_pkg::t_op'(i_op);
    assign w_accept = start && (r_state == S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_status.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) begin
                    case (w_op)
                        qvt_pkg::OP_READ:  n_state = S_READ;
                        qvt_pkg::OP_WRITE: n_state = S_WRITE;
                        qvt_pkg::OP_BEST:  n_state = S_SCAN;
                        default:           n_state = S_FINISH;
                    endcase
                end
            end
            S_READ:   n_state = S_FINISH;
            S_WRITE:  n_state = S_FINISH;
            S_SCAN: begin
                if (i_status.scan_last) n_state = S_DRAIN;
            end
            S_DRAIN:  n_state = S_FINISH;
            S_FINISH: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // state and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == S_FINISH);
        end
    end

    // commands decoded from state
    always_comb begin
        o_cmd            = '0;
        o_cmd.latch      = w_accept;
        o_cmd.clear_wr   = (r_state == S_CLEAR);
        o_cmd.write      = (r_state == S_WRITE);
        o_cmd.scan_issue = (r_state == S_SCAN);
        o_cmd.finish     = (r_state == S_FINISH);
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;

endmodule

// ===== hw/rtl/qvt_datapath.sv =====
// qvt_datapath: value table memory, index math, argmax compare and result registers
// depends on qvt_pkg; driven by commands from qvt_ctrl
`timescale 1ns / 1ps

module qvt_datapath #(
    parameter int VALUE_WIDTH = qvt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  qvt_pkg::t_ctrl_cmd                    i_cmd,
    output qvt_pkg::t_dp_status                   o_status,
    input  logic [1:0]                            i_op,
    input  logic [qvt_pkg::CODE_W-1:0]            i_scan_left,
    input  logic [qvt_pkg::CODE_W-1:0]            i_scan_right,
    input  logic [qvt_pkg::CODE_W-1:0]            i_scan_center,
    input  logic [qvt_pkg::CODE_W-1:0]            i_act_steer,
    input  logic [qvt_pkg::CODE_W-1:0]            i_act_direction,
    input  logic [qvt_pkg::CODE_W-1:0]            i_act_speed,
    input  logic signed [qvt_pkg::OUT_VALUE_W-1:0] i_write_value,
    output logic signed [qvt_pkg::OUT_VALUE_W-1:0] o_read_value,
    output logic [qvt_pkg::CODE_W-1:0]            o_best_steer,
    output logic [qvt_pkg::CODE_W-1:0]            o_best_direction,
    output logic [qvt_pkg::CODE_W-1:0]            o_best_speed,
    output logic                                  o_best_found
);

    localparam int AW = qvt_pkg::ADDR_W;
    localparam int IW = qvt_pkg::IDX_W;
    localparam int CW = qvt_pkg::CODE_W;
    localparam int OW = qvt_pkg::OUT_VALUE_W;

    // code 0 -> 0, 2 -> 1, 1 -> 2, 3 -> 0; the same map turns a digit back into a code
    function automatic logic [1:0] code_digit(input logic [1:0] c);
        logic [1:0] d;
        case (c)
            2'd1:    d = 2'd2;
            2'd2:    d = 2'd1;
            default: d = 2'd0;
        endcase
        return d;
    endfunction

    function automatic logic [IW-1:0] triple_index(input logic [1:0] c0,
                                                   input logic [1:0] c1,
                                                   input logic [1:0] c2);
        logic [IW-1:0] i0, i1, i2;
        i0 = IW'(code_digit(c0));
        i1 = IW'(code_digit(c1));
        i2 = IW'(code_digit(c2));
        return (i0 << 3) + i0 + (i1 << 1) + i1 + i2;
    endfunction

    // index 0..26 back to three codes {steer, direction, speed}
    function automatic logic [3*CW-1:0] index_codes(input logic [IW-1:0] idx);
        logic [1:0]    d0, d1, d2;
        logic [IW-1:0] rem;
        if (idx >= IW'(18)) begin
            d0 = 2'd2; rem = idx - IW'(18);
        end else if (idx >= IW'(9)) begin
            d0 = 2'd1; rem = idx - IW'(9);
        end else begin
            d0 = 2'd0; rem = idx;
        end
        if (rem >= IW'(6)) begin
            d1 = 2'd2; rem = rem - IW'(6);
        end else if (rem >= IW'(3)) begin
            d1 = 2'd1; rem = rem - IW'(3);
        end else begin
            d1 = 2'd0;
        end
        d2 = rem[1:0];
        return {code_digit(d0), code_digit(d1), code_digit(d2)};
    endfunction

    // captured beat
    qvt_pkg::t_op                r_op;
    logic [AW-1:0]               r_base;
    logic [IW-1:0]               r_act_idx;
    logic [CW-1:0]               r_act_steer, r_act_direction, r_act_speed;
    logic signed [OW-1:0]        r_wr_value;

    // memory and counters
    logic [VALUE_WIDTH-1:0]      mem [qvt_pkg::TABLE_DEPTH];
    logic [VALUE_WIDTH-1:0]      r_rd_data;
    logic [AW-1:0]               r_cnt;
    logic [AW-1:0]               w_rd_addr, w_wr_addr, w_entry_addr;
    logic [VALUE_WIDTH-1:0]      w_wr_data, w_mem_wdata;
    logic                        w_mem_we;

    // scan compare
    logic                        r_cmp_valid;
    logic [IW-1:0]               r_cmp_idx;
    logic signed [VALUE_WIDTH-1:0] r_best;
    logic [IW-1:0]               r_best_idx;
    logic                        r_found;
    logic signed [OW-1:0]        w_rd_sat;
    logic [3*CW-1:0]             w_best_codes;

    // results
    logic signed [OW-1:0]        r_read_value;
    logic [CW-1:0]               r_best_steer, r_best_direction, r_best_speed;
    logic                        r_best_found;

    // capture the input beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op            <= qvt_pkg::t_op'(i_op);
            r_base          <= AW'(triple_index(i_scan_left, i_scan_right, i_scan_center))
                               * AW'(qvt_pkg::NUM_CODES);
            r_act_idx       <= triple_index(i_act_steer, i_act_direction, i_act_speed);
            r_act_steer     <= i_act_steer;
            r_act_direction <= i_act_direction;
            r_act_speed     <= i_act_speed;
            r_wr_value      <= i_write_value;
        end
    end

    // write value into table width, saturating when the table is narrower
    generate
        if (VALUE_WIDTH >= OW) begin : g_wr_wide
            assign w_wr_data = VALUE_WIDTH'(r_wr_value);
        end else begin : g_wr_narrow
            localparam logic signed [OW-1:0] WrMax = (OW'(1) <<< (VALUE_WIDTH - 1)) - OW'(1);
            localparam logic signed [OW-1:0] WrMin = -WrMax - OW'(1);
            always_comb begin
                if (r_wr_value > WrMax)      w_wr_data = WrMax[VALUE_WIDTH-1:0];
                else if (r_wr_value < WrMin) w_wr_data = WrMin[VALUE_WIDTH-1:0];
                else                         w_wr_data = r_wr_value[VALUE_WIDTH-1:0];
            end
        end
    endgenerate

    // read value into port width, saturating when the table is wider
    generate
        if (VALUE_WIDTH <= OW) begin : g_rd_narrow
            assign w_rd_sat = OW'($signed(r_rd_data));
        end else begin : g_rd_wide
            localparam logic signed [VALUE_WIDTH-1:0] RdMax =
                (VALUE_WIDTH'(1) <<< (OW - 1)) - VALUE_WIDTH'(1);
            localparam logic signed [VALUE_WIDTH-1:0] RdMin = -RdMax - VALUE_WIDTH'(1);
            always_comb begin
                if ($signed(r_rd_data) > RdMax)      w_rd_sat = RdMax[OW-1:0];
                else if ($signed(r_rd_data) < RdMin) w_rd_sat = RdMin[OW-1:0];
                else                                 w_rd_sat = r_rd_data[OW-1:0];
            end
        end
    endgenerate

    // memory addressing
    assign w_entry_addr = r_base + AW'(r_act_idx);
    assign w_rd_addr    = i_cmd.scan_issue ? (r_base + AW'(r_cnt[IW-1:0])) : w_entry_addr;
    assign w_wr_addr    = i_cmd.clear_wr ? r_cnt : w_entry_addr;
    assign w_mem_wdata  = i_cmd.clear_wr ? '0 : w_wr_data;
    assign w_mem_we     = i_cmd.clear_wr || i_cmd.write;

    // table memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) mem[w_wr_addr] <= w_mem_wdata;
        r_rd_data <= mem[w_rd_addr];
    end

    // sweep and scan counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.latch) begin
            r_cnt <= '0;
        end else if (i_cmd.clear_wr || i_cmd.scan_issue) begin
            r_cnt <= r_cnt + AW'(1);
        end
    end

    assign o_status.clear_last = (r_cnt == AW'(qvt_pkg::TABLE_DEPTH - 1));
    assign o_status.scan_last  = (r_cnt[IW-1:0] == IW'(qvt_pkg::NUM_CODES - 1));

    // argmax over the returning scan reads, first strictly greater wins
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_valid <= 1'b0;
        end else begin
            r_cmp_valid <= i_cmd.scan_issue;
        end
        r_cmp_idx <= r_cnt[IW-1:0];
        if (i_cmd.latch) begin
            r_best     <= '0;
            r_best_idx <= '0;
            r_found    <= 1'b0;
        end else if (r_cmp_valid && ($signed(r_rd_data) > r_best)) begin
            r_best     <= $signed(r_rd_data);
            r_best_idx <= r_cmp_idx;
            r_found    <= 1'b1;
        end
    end

    assign w_best_codes = index_codes(r_best_idx);

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            case (r_op)
                qvt_pkg::OP_READ: begin
                    r_read_value     <= w_rd_sat;
                    r_best_steer     <= '0;
                    r_best_direction <= '0;
                    r_best_speed     <= '0;
                    r_best_found     <= 1'b0;
                end
                qvt_pkg::OP_BEST: begin
                    r_read_value <= '0;
                    if (r_found) begin
                        r_best_steer     <= w_best_codes[3*CW-1:2*CW];
                        r_best_direction <= w_best_codes[2*CW-1:CW];
                        r_best_speed     <= w_best_codes[CW-1:0];
                    end else begin
                        r_best_steer     <= r_act_steer;
                        r_best_direction <= r_act_direction;
                        r_best_speed     <= r_act_speed;
                    end
                    r_best_found <= r_found;
                end
                default: begin
                    r_read_value     <= '0;
                    r_best_steer     <= '0;
                    r_best_direction <= '0;
                    r_best_speed     <= '0;
                    r_best_found     <= 1'b0;
                end
            endcase
        end
    end

    assign o_read_value     = r_read_value;
    assign o_best_steer     = r_best_steer;
    assign o_best_direction = r_best_direction;
    assign o_best_speed     = r_best_speed;
    assign o_best_found     = r_best_found;

endmodule

// ===== hw/rtl/q_value_table_with_argmax.sv =====
// Q value table with argmax: 27 states x 27 actions of signed fixed point values.
// An accepted beat passes its op state (read, write, or scan and drain; none for a no-op)
// and the finish state; o_strobe is registered from finish and busy drops in that strobe
// cycle. The best-action op reads the 27 action entries in turn through the one read port
// and drains the compare. After reset all 729 entries are swept to zero with busy high.
// The receiver cannot stall: o_strobe marks each result for exactly one cycle.
`timescale 1ns / 1ps

module q_value_table_with_argmax #(
    parameter int VALUE_WIDTH = qvt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [1:0]                             i_op,
    input  logic [qvt_pkg::CODE_W-1:0]             i_scan_left,
    input  logic [qvt_pkg::CODE_W-1:0]             i_scan_right,
    input  logic [qvt_pkg::CODE_W-1:0]             i_scan_center,
    input  logic [qvt_pkg::CODE_W-1:0]             i_act_steer,
    input  logic [qvt_pkg::CODE_W-1:0]             i_act_direction,
    input  logic [qvt_pkg::CODE_W-1:0]             i_act_speed,
    input  logic signed [qvt_pkg::OUT_VALUE_W-1:0] i_write_value,
    output logic                                   o_strobe,
    output logic signed [qvt_pkg::OUT_VALUE_W-1:0] o_read_value,
    output logic [qvt_pkg::CODE_W-1:0]             o_best_steer,
    output logic [qvt_pkg::CODE_W-1:0]             o_best_direction,
    output logic [qvt_pkg::CODE_W-1:0]             o_best_speed,
    output logic                                   o_best_found
);

    qvt_pkg::t_ctrl_cmd  w_cmd;
    qvt_pkg::t_dp_status w_status;

    // sequencing
    qvt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_op     (i_op),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .busy     (busy),
        .o_strobe (o_strobe)
    );

    // table, scan and results
    qvt_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_op             (i_op),
        .i_scan_left      (i_scan_left),
        .i_scan_right     (i_scan_right),
        .i_scan_center    (i_scan_center),
        .i_act_steer      (i_act_steer),
        .i_act_direction  (i_act_direction),
        .i_act_speed      (i_act_speed),
        .i_write_value    (i_write_value),
        .o_read_value     (o_read_value),
        .o_best_steer     (o_best_steer),
        .o_best_direction (o_best_direction),
        .o_best_speed     (o_best_speed),
        .o_best_found     (o_best_found)
    );

endmodule
